// File: hw/rtl/variable_slope_lowpass_unit_assert.svh
// Assertion macros for the variable-slope lowpass unit.
// Each check is clocked on the rising edge and is disabled while reset is low.
`ifndef VARIABLE_SLOPE_LOWPASS_UNIT_ASSERT_SVH
`define VARIABLE_SLOPE_LOWPASS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define VSL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define VSL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VSL_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define VSL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hw/rtl/vsl_pkg.sv
package vsl_pkg;

    // Configuration register formats.
    localparam int AMOUNT_W    = 17;
    localparam int TIGHT_W     = 18;
    localparam int POLES_W     = 19;
    localparam int WET_W       = 17;
    localparam int CFG_DATA_W  = 19;
    localparam int CFG_INDEX_W = 2;

    // Coefficient in Q24 (up to and including one) and the second multiplier operand.
    localparam int COEF_W = 25;
    localparam int MUL_B_W = 26;

    localparam logic [16:0] UNITY_Q16 = 17'h10000;
    localparam logic [18:0] POLES_MAX = 19'h40000;
    localparam logic [COEF_W-1:0] COEF_MAX = 25'h1000000;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_AMOUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POLES  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WET    = 2'd3;

    // Operations of the shared multiply-round-clamp unit.
    localparam logic [2:0] OP_OFFSET = 3'd0;
    localparam logic [2:0] OP_COEF   = 3'd1;
    localparam logic [2:0] OP_FILTER = 3'd2;
    localparam logic [2:0] OP_MIX    = 3'd3;
    localparam logic [2:0] OP_WET    = 3'd4;

    // Partial mix of stage k: pole count minus k, limited to the range zero to one.
    function automatic logic [16:0] stage_weight(input logic [18:0] poles, input logic [2:0] k);
        logic signed [20:0] d;
        d = $signed({2'b00, poles}) - $signed({2'b00, k, 16'h0000});
        if (d < 0) begin
            return 17'd0;
        end else if (d > $signed({4'b0000, UNITY_Q16})) begin
            return UNITY_Q16;
        end else begin
            return d[16:0];
        end
    endfunction

endpackage

// File: hw/rtl/variable_slope_lowpass_unit.sv
// Variable-slope lowpass: each transfer on the s_ side carries one signed sample and yields
// one filtered, saturated sample on the m_ side. A single multiplier, followed by a
// round-add-clamp step, is reused for every product: the signal-dependent offset, the
// coefficient, two products for each engaged stage and the dry/wet blend. A product is
// formed in ST_MUL and then rounded, added and clamped in ST_ACC. A finished result waits
// in ST_OUT while an earlier result still waits in the output register for m_tready;
// s_tready is low from the transfer of a sample until its result enters the output
// register. The output register lets the next sample be taken while a result still
// waits for m_tready. Configuration writes are taken at any time and must
// only be issued while no sample is in flight.
`include "variable_slope_lowpass_unit_assert.svh"

module variable_slope_lowpass_unit
    import vsl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int STAGES = 4,
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // sample_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DATA_W-1:0]      m_tdata    // sample_out
);

    localparam int FB = SAMPLE_BITS - 1;
    localparam int AW = SAMPLE_BITS + 2;
    localparam int PW = AW + MUL_B_W;
    localparam int SW = PW + 1;
    localparam int KW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(STAGES - 1);

    localparam logic signed [PW-1:0] HALF_FB = PW'(1) << (FB - 1);
    localparam logic signed [PW-1:0] HALF_8  = PW'(1) << 7;
    localparam logic signed [PW-1:0] HALF_16 = PW'(1) << 15;
    localparam logic signed [PW-1:0] HALF_24 = PW'(1) << 23;
    localparam logic signed [SW-1:0] SAT_HI  = (SW'(1) << FB) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO  = -SAT_HI - SW'(1);
    localparam logic signed [SAMPLE_BITS:0] ONE_S = (SAMPLE_BITS + 1)'(1) << FB;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic [KW-1:0] k_reg, k_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] dry_reg, dry_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [SAMPLE_BITS-1:0] bank_reg [2][STAGES];
    logic bank_sel_reg;
    logic out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    logic [AMOUNT_W-1:0] amount_reg, amount_next;
    logic signed [TIGHT_W-1:0] tight_reg, tight_next;
    logic [POLES_W-1:0] poles_reg, poles_next;
    logic [WET_W-1:0] wet_reg, wet_next;

    logic bank_we;
    logic out_load;
    logic bank_idx;
    logic signed [SAMPLE_BITS-1:0] s_cur;
    logic [16:0] w_cur;
    logic [16:0] tight_abs;
    logic signed [SAMPLE_BITS:0] dry_ext, x_ext, s_ext, mag, off_sel;
    logic signed [AW-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0] rnd;
    logic signed [SW-1:0] base, lo, hi, sum, acc_val;

    logic [16:0] amt_in, wet_in;
    logic signed [17:0] t_in, t_clip;
    logic [15:0] t_half;

    // ---------------------------------------------------------------- configuration
    always_comb begin
        amount_next = amount_reg;
        tight_next  = tight_reg;
        poles_next  = poles_reg;
        wet_next    = wet_reg;
        amt_in = cfg_data[16:0];
        wet_in = cfg_data[16:0];
        t_in   = $signed(cfg_data[17:0]);
        if (t_in > $signed({1'b0, UNITY_Q16})) begin
            t_clip = $signed({1'b0, UNITY_Q16});
        end else if (t_in < -$signed({1'b0, UNITY_Q16})) begin
            t_clip = -$signed({1'b0, UNITY_Q16});
        end else begin
            t_clip = t_in;
        end
        // Negative settings are halved with the magnitude rounded down.
        t_half = 16'(17'(-t_clip) >> 1);
        if (cfg_we) begin
            case (cfg_index)
                REG_AMOUNT: begin
                    if (amt_in == 17'd0) begin
                        amount_next = 17'd1;
                    end else if (amt_in > UNITY_Q16) begin
                        amount_next = UNITY_Q16;
                    end else begin
                        amount_next = amt_in;
                    end
                end
                REG_TIGHT: begin
                    if (t_clip < 0) begin
                        tight_next = -$signed({2'b00, t_half});
                    end else begin
                        tight_next = t_clip;
                    end
                end
                REG_POLES: begin
                    poles_next = (cfg_data > POLES_MAX) ? POLES_MAX : cfg_data;
                end
                REG_WET: begin
                    wet_next = (wet_in > UNITY_Q16) ? UNITY_Q16 : wet_in;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- operands
    assign bank_idx  = ~bank_sel_reg;
    assign s_cur     = bank_reg[bank_idx][k_reg];
    assign w_cur     = stage_weight(poles_reg, 3'(k_reg));
    assign tight_abs = tight_reg[TIGHT_W-1] ? 17'(-tight_reg) : tight_reg[16:0];
    assign dry_ext   = {dry_reg[SAMPLE_BITS-1], dry_reg};
    assign x_ext     = {x_reg[SAMPLE_BITS-1], x_reg};
    assign s_ext     = {s_cur[SAMPLE_BITS-1], s_cur};
    assign mag       = (dry_ext < 0) ? -dry_ext : dry_ext;
    // A soft setting weighs the magnitude, a hard one its distance from full scale.
    assign off_sel   = tight_reg[TIGHT_W-1] ? (ONE_S - mag) : mag;

    always_comb begin
        case (op_reg)
            OP_OFFSET: begin
                mul_a = AW'(off_sel);
                mul_b = MUL_B_W'(tight_reg);
            end
            OP_COEF: begin
                mul_a = AW'($signed({1'b0, coef_reg[16:0]}));
                mul_b = MUL_B_W'($signed({1'b0, amount_reg}));
            end
            OP_FILTER: begin
                mul_a = AW'(x_ext - s_ext);
                mul_b = MUL_B_W'($signed({1'b0, coef_reg}));
            end
            OP_MIX: begin
                mul_a = AW'(s_ext - x_ext);
                mul_b = MUL_B_W'($signed({1'b0, w_cur}));
            end
            OP_WET: begin
                mul_a = AW'(x_ext - dry_ext);
                mul_b = MUL_B_W'($signed({1'b0, wet_reg}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- round, add, clamp
    always_comb begin
        case (op_reg)
            OP_OFFSET: begin
                rnd  = (prod_reg + HALF_FB) >>> FB;
                base = SW'($signed({1'b0, UNITY_Q16 - tight_abs}));
                lo   = SW'(1);
                hi   = SW'($signed({1'b0, UNITY_Q16}));
            end
            OP_COEF: begin
                rnd  = (prod_reg + HALF_8) >>> 8;
                base = '0;
                lo   = SW'(1);
                hi   = SW'($signed({1'b0, COEF_MAX}));
            end
            OP_FILTER: begin
                rnd  = (prod_reg + HALF_24) >>> 24;
                base = SW'(s_cur);
                lo   = SAT_LO;
                hi   = SAT_HI;
            end
            OP_MIX: begin
                rnd  = (prod_reg + HALF_16) >>> 16;
                base = SW'(x_reg);
                lo   = SAT_LO;
                hi   = SAT_HI;
            end
            OP_WET: begin
                rnd  = (prod_reg + HALF_16) >>> 16;
                base = SW'(dry_reg);
                lo   = SAT_LO;
                hi   = SAT_HI;
            end
            default: begin
                rnd  = '0;
                base = '0;
                lo   = SAT_LO;
                hi   = SAT_HI;
            end
        endcase
        sum = base + SW'(rnd);
        if (sum < lo) begin
            acc_val = lo;
        end else if (sum > hi) begin
            acc_val = hi;
        end else begin
            acc_val = sum;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        dry_next   = dry_reg;
        coef_next  = coef_reg;
        prod_next  = prod_reg;
        bank_we    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = $signed(s_tdata[SAMPLE_BITS-1:0]);
                    dry_next   = $signed(s_tdata[SAMPLE_BITS-1:0]);
                    op_next    = OP_OFFSET;
                    k_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ACC;
                // Stages with zero weight, and all after them, are bypassed.
                if (op_reg == OP_FILTER && w_cur == 17'd0) begin
                    op_next    = OP_WET;
                    state_next = ST_MUL;
                end else if (op_reg == OP_WET && wet_reg == UNITY_Q16) begin
                    state_next = ST_OUT;
                end
            end
            ST_ACC: begin
                state_next = ST_MUL;
                case (op_reg)
                    OP_OFFSET: begin
                        coef_next = acc_val[COEF_W-1:0];
                        op_next   = OP_COEF;
                    end
                    OP_COEF: begin
                        coef_next = acc_val[COEF_W-1:0];
                        op_next   = OP_FILTER;
                    end
                    OP_FILTER: begin
                        bank_we = 1'b1;
                        op_next = OP_MIX;
                    end
                    OP_MIX: begin
                        x_next = acc_val[SAMPLE_BITS-1:0];
                        if (k_reg == K_LAST) begin
                            op_next = OP_WET;
                        end else begin
                            k_next  = k_reg + KW'(1);
                            op_next = OP_FILTER;
                        end
                    end
                    OP_WET: begin
                        x_next     = acc_val[SAMPLE_BITS-1:0];
                        state_next = ST_OUT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_OFFSET;
            k_reg         <= '0;
            bank_sel_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            amount_reg    <= 17'd1;
            tight_reg     <= '0;
            poles_reg     <= 19'h10000;
            wet_reg       <= UNITY_Q16;
            for (int b = 0; b < 2; b++) begin
                for (int k = 0; k < STAGES; k++) begin
                    bank_reg[b][k] <= '0;
                end
            end
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            amount_reg    <= amount_next;
            tight_reg     <= tight_next;
            poles_reg     <= poles_next;
            wet_reg       <= wet_next;
            if (out_load) begin
                bank_sel_reg <= ~bank_sel_reg;
            end
            if (bank_we) begin
                bank_reg[bank_idx][k_reg] <= acc_val[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        dry_reg  <= dry_next;
        coef_reg <= coef_next;
        prod_reg <= prod_next;
        if (out_load) begin
            out_data_reg <= x_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

    // ---------------------------------------------------------------- checks
    `VSL_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_tvalid && s_tready, !s_tready, "sample taken while the previous one is in work")
    `VSL_ASSERT_IMP(a_coef_in_range, aclk, aresetn, state_reg == ST_MUL && op_reg == OP_FILTER, coef_reg != '0 && coef_reg <= COEF_MAX, "coefficient out of range")
    `VSL_ASSERT_NEXT(a_bank_alternates, aclk, aresetn, out_load, bank_sel_reg != $past(bank_sel_reg), "state bank did not alternate")
    `VSL_ASSERT_NEXT(a_result_registered, aclk, aresetn, out_load, m_tvalid && state_reg == ST_IDLE, "result not presented after completion")

endmodule
